### design/assert_macros.svh
// Assertion shorthands, clocked on clk_i and silenced while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### design/mcl_pkg.sv
package mcl_pkg;

  localparam int unsigned LOG_ENTRIES_DEFAULT = 1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned QUARTER_TURN  = 11520;
  localparam int unsigned HALF_TURN     = 23040;
  localparam int unsigned RAD_PER_UNIT  = 146409;
  localparam int unsigned BT_LIMIT      = 36352;
  localparam int unsigned BT_REF        = 36480;
  localparam int unsigned LN2_Q28       = 186065280;
  localparam logic [30:0] ONE_Q30       = 31'd1 << 30;

  // Taylor divisors of the cos series and their 2^32 reciprocals
  localparam int unsigned COS_DIV [4] = '{90, 56, 30, 12};
  localparam logic [31:0] DIV_RECIP [4] = '{
    32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12)
  };

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_BAD   = 2'd1,
    ST_SKIP  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WATER_THR  = 3'd0,
    REG_TEMP_FLOOR = 3'd1,
    REG_C1         = 3'd2,
    REG_C2         = 3'd3,
    REG_C3         = 3'd4,
    REG_COEF_LOW   = 3'd5,
    REG_COEF_HIGH  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [14:0] zenith_angle;
    logic [15:0]        surface_temp;
    logic [15:0]        water_fraction;
    logic [15:0]        temp_low_channel;
    logic [15:0]        temp_high_channel;
  } item_t;

  typedef struct packed {
    logic [15:0] water_path;
    logic [1:0]  status;
  } result_t;

  // Shift-subtract division, used only to build constant tables.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    int          k;
    q = '0;
    r = '0;
    for (k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + idx/n) in Q28 from the atanh series to the z^23 term
  function automatic logic [27:0] ln_entry(int unsigned idx, int unsigned n);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] sum;
    logic [63:0] p;
    int unsigned k;
    z   = udiv64(64'(idx) << 30, 64'(2 * n + idx));
    z2  = (z * z) >> 30;
    sum = z;
    p   = z;
    for (k = 3; k <= 23; k += 2) begin
      p   = (p * z2) >> 30;
      sum = sum + udiv64(p, 64'(k));
    end
    return sum[28:1];
  endfunction

  // Position of the leading one, at least 7
  function automatic logic [3:0] msb_pos(logic [15:0] v);
    logic [3:0] e;
    int         k;
    e = 4'd7;
    for (k = 8; k < 16; k++) begin
      if (v[k]) e = 4'(k);
    end
    return e;
  endfunction

endpackage

### design/microwave_cloud_liquid_water.sv
// Cloud liquid water retrieval from two microwave brightness temperatures.
// Input: drive item_i with start high; a word is taken on a rising edge
// where start is high and busy is low. One word can be taken every cycle while busy is low.
// Output: every taken word gives exactly one result word on res_o, shown
// for one cycle with res_valid_o high, at the end of the vld_q chain.
// Results leave in input order; the receiver cannot stall, and nothing
// inside the pipeline ever waits.
// Status is valid, bad value or skipped (not over water); water_path is
// zero unless the status is valid.
// Config: write register cfg_index_i with cfg_data_i when cfg_valid_i is
// high; cfg_ready_o is always high, unknown indexes are dropped. Write only
// while no word is in flight.
// Reset: config registers take their defaults, and busy stays high while the
// log table memory is loaded, one row per cycle, until its LOG_TABLE_ENTRIES
// rows are in. Config writes are taken during that time.
// Throughput is one word per cycle while busy is low, through the 16 register
// stages of the cos series, log lookup and product datapath.
`include "assert_macros.svh"

module microwave_cloud_liquid_water import mcl_pkg::*; #(
  parameter int unsigned LOG_TABLE_ENTRIES = LOG_ENTRIES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item_i,
  output logic                  res_valid_o,
  output result_t               res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned POS_W = 16 + IDX_W;
  localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(LOG_TABLE_ENTRIES - 1);
  localparam int unsigned LAST = 15;

  // ---------------- configuration ----------------
  logic [15:0]        thr_q, floor_q;
  logic signed [16:0] c1_q, c2_q, c3_q, cl_q, ch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 16'd32440;
      floor_q <= 16'd34835;
      c1_q    <= 17'sd33751;
      c2_q    <= 17'sd10740;
      c3_q    <= 17'sd7561;
      cl_q    <= 17'sd3088;
      ch_q    <= -17'sd9277;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WATER_THR:  thr_q   <= cfg_data_i[15:0];
        REG_TEMP_FLOOR: floor_q <= cfg_data_i[15:0];
        REG_C1:         c1_q    <= $signed(cfg_data_i);
        REG_C2:         c2_q    <= $signed(cfg_data_i);
        REG_C3:         c3_q    <= $signed(cfg_data_i);
        REG_COEF_LOW:   cl_q    <= $signed(cfg_data_i);
        REG_COEF_HIGH:  ch_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- log table memory ----------------
  logic [55:0]      pair_rom [LOG_TABLE_ENTRIES];
  logic [55:0]      mem [LOG_TABLE_ENTRIES];
  logic [IDX_W-1:0] fill_cnt_q;
  logic             filling_q;

  for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [27:0] LO = ln_entry(g, LOG_TABLE_ENTRIES);
    localparam logic [27:0] HI = ln_entry(g + 1, LOG_TABLE_ENTRIES);
    assign pair_rom[g] = {HI, LO};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
      filling_q  <= 1'b1;
    end else if (filling_q) begin
      fill_cnt_q <= fill_cnt_q + 1'b1;
      if (fill_cnt_q == FILL_LAST) filling_q <= 1'b0;
    end
  end

  assign busy = filling_q;

  // ---------------- pipeline control ----------------
  logic    accept;
  logic    vld_q [1:LAST];
  status_e st_q  [1:LAST];
  logic    neg_q [1:10];

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAST; k++) vld_q[k] <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      vld_q[1] <= accept;
      for (int k = 2; k <= LAST; k++) vld_q[k] <= vld_q[k-1];
      res_valid_o <= vld_q[LAST];
    end
  end

  // ---------------- stage 1: fold angle, checks ----------------
  logic [14:0] a_abs;
  logic [13:0] s1_t_d, s1_t_q;
  logic        neg_d;
  status_e     st_d;
  logic [15:0] s1_v_d [2];
  logic [15:0] s1_v_q [2];

  always_comb begin
    a_abs = item_i.zenith_angle[14] ? 15'(-item_i.zenith_angle)
                                    : 15'(item_i.zenith_angle);
    if (a_abs > 15'(QUARTER_TURN)) begin
      s1_t_d = 14'(15'(HALF_TURN) - a_abs);
      neg_d  = 1'b1;
    end else begin
      s1_t_d = 14'(a_abs);
      neg_d  = 1'b0;
    end
    if (item_i.water_fraction < thr_q) begin
      st_d = ST_SKIP;
    end else if (!(item_i.surface_temp > floor_q &&
                   item_i.temp_low_channel <= 16'(BT_LIMIT) &&
                   item_i.temp_high_channel <= 16'(BT_LIMIT) &&
                   item_i.temp_low_channel != '0 &&
                   item_i.temp_high_channel != '0)) begin
      st_d = ST_BAD;
    end else begin
      st_d = ST_VALID;
    end
    s1_v_d[0] = 16'(BT_REF) - item_i.temp_low_channel;
    s1_v_d[1] = 16'(BT_REF) - item_i.temp_high_channel;
  end

  // ---------------- stage 2: angle to radians, log normalize ----------------
  logic [30:0]      s2_x_d, s2_x_q;
  logic [3:0]       s2_e_d [2];
  logic [3:0]       s2_e_q [2];
  logic [15:0]      s2_w_d [2];
  logic [15:0]      s2_w_q [2];
  logic [IDX_W-1:0] rd_idx [2];
  logic [55:0]      rd_q [2];
  logic [4:0]       sh [2];
  logic [31:0]      shifted [2];
  logic [POS_W-1:0] pos [2];

  always_comb begin
    s2_x_d = 31'(32'(s1_t_q) * 32'(RAD_PER_UNIT));
    for (int ch = 0; ch < 2; ch++) begin
      s2_e_d[ch]  = msb_pos(s1_v_q[ch]);
      sh[ch]      = 5'd16 - {1'b0, s2_e_d[ch]};
      shifted[ch] = 32'(s1_v_q[ch]) << sh[ch];
      pos[ch]     = POS_W'(shifted[ch][15:0]) * POS_W'(LOG_TABLE_ENTRIES);
      rd_idx[ch]  = pos[ch][POS_W-1:16];
      s2_w_d[ch]  = pos[ch][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (filling_q) mem[fill_cnt_q] <= pair_rom[fill_cnt_q];
    rd_q[0] <= mem[rd_idx[0]];
    rd_q[1] <= mem[rd_idx[1]];
  end

  // ---------------- stage 3: square partials, interpolate ----------------
  logic [29:0] s3_hh_d, s3_hh_q;
  logic [30:0] s3_hl_d, s3_hl_q;
  logic [31:0] s3_ll_d, s3_ll_q;
  logic [27:0] s3_lo_d [2];
  logic [27:0] s3_lo_q [2];
  logic [27:0] s3_ip_d [2];
  logic [27:0] s3_ip_q [2];
  logic [3:0]  s3_e_q [2];
  logic [27:0] diff [2];
  logic [43:0] ipw [2];

  always_comb begin
    s3_hh_d = 30'(s2_x_q[30:16]) * 30'(s2_x_q[30:16]);
    s3_hl_d = 31'(s2_x_q[30:16]) * 31'(s2_x_q[15:0]);
    s3_ll_d = 32'(s2_x_q[15:0]) * 32'(s2_x_q[15:0]);
    for (int ch = 0; ch < 2; ch++) begin
      s3_lo_d[ch] = rd_q[ch][27:0];
      diff[ch]    = rd_q[ch][55:28] - rd_q[ch][27:0];
      ipw[ch]     = 44'(diff[ch]) * 44'(s2_w_q[ch]);
      s3_ip_d[ch] = ipw[ch][43:16];
    end
  end

  // ---------------- stage 4: x squared, log sum ----------------
  logic [61:0] xsq;
  logic [31:0] s4_x2_d, s4_x2_q;
  logic [30:0] s4_ln_d [2];
  logic [30:0] s4_ln_q [2];

  always_comb begin
    xsq = (62'(s3_hh_q) << 32) + (62'(s3_hl_q) << 17) + 62'(s3_ll_q);
    s4_x2_d = xsq[61:30];
    for (int ch = 0; ch < 2; ch++) begin
      s4_ln_d[ch] = 31'(s3_lo_q[ch]) + 31'(s3_ip_q[ch])
                  + 31'(s3_e_q[ch] - 4'd7) * 31'(LN2_Q28);
    end
  end

  // ---------------- stage 5: reciprocal estimates, log weights ----------------
  logic [60:0]        rprod [4];
  logic [28:0]        s5_q0_d [4];
  logic [28:0]        s5_q0_q [4];
  logic [31:0]        s5_x2_q;
  logic signed [48:0] s5_t_d [2];
  logic signed [48:0] s5_t_q [2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rprod[k]   = 61'(s4_x2_q) * 61'(DIV_RECIP[k]);
      s5_q0_d[k] = rprod[k][60:32];
    end
    s5_t_d[0] = 49'(cl_q) * $signed(49'({1'b0, s4_ln_q[0]}));
    s5_t_d[1] = 49'(ch_q) * $signed(49'({1'b0, s4_ln_q[1]}));
  end

  // ---------------- stage 6: quotient correction, log total ----------------
  logic [31:0]        rem [4];
  logic [28:0]        s6_q_d [4];
  logic [28:0]        s6_q_q [4];
  logic [30:0]        s6_x2h_q;
  logic signed [51:0] l_d;
  logic signed [51:0] l_q [6:13];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem[k]    = s5_x2_q - 32'(s5_q0_q[k]) * 32'(COS_DIV[k]);
      s6_q_d[k] = s5_q0_q[k] + 29'(rem[k] >= 32'(COS_DIV[k]));
    end
    l_d = (52'(s5_t_q[0]) + 52'(s5_t_q[1])) <<< 2;
  end

  // ---------------- stages 7..10: nested series ----------------
  logic [30:0] p1, p2, p3, p4;
  logic [59:0] m7, m8, m9;
  logic [61:0] m10;
  logic [29:0] s7_mh_d, s7_mh_q, s8_mh_d, s8_mh_q, s9_mh_d, s9_mh_q;
  logic [28:0] s7_q30_q, s7_q12_q, s8_q12_q;
  logic [30:0] s7_x2h_q, s8_x2h_q, s9_x2h_q;
  logic [31:0] s10_q_d, s10_q_q;

  always_comb begin
    p1      = ONE_Q30 - 31'(s6_q_q[0]);
    m7      = 60'(s6_q_q[1]) * 60'(p1);
    s7_mh_d = m7[59:30];
    p2      = ONE_Q30 - 31'(s7_mh_q);
    m8      = 60'(s7_q30_q) * 60'(p2);
    s8_mh_d = m8[59:30];
    p3      = ONE_Q30 - 31'(s8_mh_q);
    m9      = 60'(s8_q12_q) * 60'(p3);
    s9_mh_d = m9[59:30];
    p4      = ONE_Q30 - 31'(s9_mh_q);
    m10     = 62'(s9_x2h_q) * 62'(p4);
    s10_q_d = m10[61:30];
  end

  // ---------------- stage 11: cos to Q15 ----------------
  logic [30:0]        cq;
  logic [30:0]        cr_w;
  logic signed [16:0] cs_d;
  logic signed [16:0] cs_q [11:14];

  always_comb begin
    cq   = (s10_q_q >= 32'(ONE_Q30)) ? 31'd0 : 31'(32'(ONE_Q30) - s10_q_q);
    cr_w = (cq + 31'd16384) >> 15;
    cs_d = neg_q[10] ? -$signed({1'b0, cr_w[15:0]}) : $signed({1'b0, cr_w[15:0]});
  end

  // ---------------- stages 12..16: polynomial and product ----------------
  logic signed [33:0] s12_in_d, s12_in_q;
  logic signed [50:0] s13_ic_d, s13_ic_q;
  logic signed [53:0] s42;
  logic signed [53:0] s42_sh;
  logic signed [38:0] s14_s27_d, s14_s27_q;
  logic signed [55:0] s15_pr_d, s15_pr_q;
  logic signed [55:0] rnd;
  result_t            res_d;

  always_comb begin
    s12_in_d  = (34'(c2_q) <<< 15) - 34'(c3_q) * 34'(cs_q[11]);
    s13_ic_d  = 51'(s12_in_q) * 51'(cs_q[12]);
    s42       = (54'(c1_q) <<< 30) - 54'(s13_ic_q) + 54'(l_q[13]);
    s42_sh    = s42 >>> 15;
    s14_s27_d = 39'(s42_sh);
    s15_pr_d  = 56'(s14_s27_q) * 56'(cs_q[14]);
    rnd       = s15_pr_q + 56'sd536870912;
    res_d.status = st_q[LAST];
    if (st_q[LAST] != ST_VALID || s15_pr_q <= 56'sd0) begin
      res_d.water_path = '0;
    end else if (rnd[55:30] > 26'd65535) begin
      res_d.water_path = 16'hffff;
    end else begin
      res_d.water_path = rnd[45:30];
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    s1_t_q   <= s1_t_d;
    neg_q[1] <= neg_d;
    st_q[1]  <= st_d;
    for (int k = 2; k <= 10; k++) neg_q[k] <= neg_q[k-1];
    for (int k = 2; k <= LAST; k++) st_q[k] <= st_q[k-1];
    for (int ch = 0; ch < 2; ch++) begin
      s1_v_q[ch]  <= s1_v_d[ch];
      s2_e_q[ch]  <= s2_e_d[ch];
      s2_w_q[ch]  <= s2_w_d[ch];
      s3_lo_q[ch] <= s3_lo_d[ch];
      s3_ip_q[ch] <= s3_ip_d[ch];
      s3_e_q[ch]  <= s2_e_q[ch];
      s4_ln_q[ch] <= s4_ln_d[ch];
      s5_t_q[ch]  <= s5_t_d[ch];
    end
    s2_x_q  <= s2_x_d;
    s3_hh_q <= s3_hh_d;
    s3_hl_q <= s3_hl_d;
    s3_ll_q <= s3_ll_d;
    s4_x2_q <= s4_x2_d;
    for (int k = 0; k < 4; k++) begin
      s5_q0_q[k] <= s5_q0_d[k];
      s6_q_q[k]  <= s6_q_d[k];
    end
    s5_x2_q  <= s4_x2_q;
    s6_x2h_q <= s5_x2_q[31:1];
    l_q[6]   <= l_d;
    for (int k = 7; k <= 13; k++) l_q[k] <= l_q[k-1];
    s7_mh_q  <= s7_mh_d;
    s7_q30_q <= s6_q_q[2];
    s7_q12_q <= s6_q_q[3];
    s7_x2h_q <= s6_x2h_q;
    s8_mh_q  <= s8_mh_d;
    s8_q12_q <= s7_q12_q;
    s8_x2h_q <= s7_x2h_q;
    s9_mh_q  <= s9_mh_d;
    s9_x2h_q <= s8_x2h_q;
    s10_q_q  <= s10_q_d;
    cs_q[11] <= cs_d;
    for (int k = 12; k <= 14; k++) cs_q[k] <= cs_q[k-1];
    s12_in_q  <= s12_in_d;
    s13_ic_q  <= s13_ic_d;
    s14_s27_q <= s14_s27_d;
    s15_pr_q  <= s15_pr_d;
    res_o     <= res_d;
  end

  // ---------------- assertions ----------------
  `ASSERT_PROP(a_busy_stays_low, !busy |=> !busy, "busy rose after table load")
  `ASSERT_PROP(a_word_returns, start && !busy |-> ##16 res_valid_o, "result word missing")
  `ASSERT_PROP(a_no_stray_result, res_valid_o |-> $past(start && !busy, 16),
               "result word without input")
  `ASSERT_NEVER(a_zero_unless_valid,
                res_valid_o && res_o.status != ST_VALID && res_o.water_path != '0,
                "nonzero water path on rejected word")

endmodule
